### hw/rtl/substring_first_match_unit_assert.svh
// Assertion macros used by the substring search top level.
// Expects signals clk and arst_n in the scope of each use.
`ifndef SUBSTRING_FIRST_MATCH_UNIT_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_UNIT_ASSERT_SVH

// same-cycle implication
`define SFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sfm_pkg.sv
// Types and constants for the substring search unit.
// No dependencies.
package sfm_pkg;

	localparam int PAT_CHARS = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int LEN_W = 5;
	localparam int POS_W = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

	typedef logic [PAT_CHARS-1:0][7:0] pat_chars_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic last_char;
	} in_beat_t;

	typedef struct packed {
		logic found;
		logic [POS_W-1:0] match_position;
		logic too_long;
	} out_beat_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

### hw/rtl/sfm_cell.sv
// One window cell: holds a past text character and checks it against its pattern slot.
// Depends on sfm_pkg.
module sfm_cell #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input sfm_pkg::cell_ctl_t ctl,
	input logic [7:0] char_in,
	input sfm_pkg::pat_chars_t pat,
	input logic [sfm_pkg::LEN_W-1:0] len,
	output logic [7:0] char_out,
	output logic hit
);

	localparam logic [sfm_pkg::LEN_W-1:0] NEED = sfm_pkg::LEN_W'(IDX + 2);

	logic [7:0] char_q;
	logic [sfm_pkg::LEN_W-1:0] sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
		end else if (ctl.clear) begin
			char_q <= '0;
		end else if (ctl.shift) begin
			char_q <= char_in;
		end
	end

	assign sel = len - NEED;
	assign char_out = char_q;
	assign hit = (len < NEED) || (char_q == pat[sel[3:0]]);

endmodule

### hw/rtl/sfm_out_buf.sv
// Two-entry result buffer between the search core and the output channel.
// Depends on sfm_pkg.
module sfm_out_buf (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sfm_pkg::out_beat_t push_data,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output sfm_pkg::out_beat_t out_data
);

	sfm_pkg::out_beat_t mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = out_valid && !out_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign out_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/substring_first_match_unit.sv
// Top level of the streaming substring search: pattern registers, window cell row, result buffer.
// Depends on sfm_pkg, sfm_cell, sfm_out_buf and substring_first_match_unit_assert.svh.
//
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_stall   | in_data   (text_char, last_char)
// out      | output    | out_valid/out_stall | out_data  (found, match_position, too_long)
// cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// One character beat per cycle while in_stall is low; the window compare is combinational parallel cell checks.
// A result beat is queued in a two-entry buffer the cycle after the last character.
// in_stall rises only when both buffer entries are occupied.
// Reset clears pattern registers, window cells, counters and the buffer; no clearing pass.
`include "substring_first_match_unit_assert.svh"

module substring_first_match_unit #(
	parameter int PATTERN_MAX = 16,
	parameter int TEXT_MAX = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input sfm_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output sfm_pkg::out_beat_t out_data,
	input logic cfg_we,
	input logic [sfm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [sfm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = PATTERN_MAX - 1;
	localparam int CW = $clog2(TEXT_MAX + 1);
	localparam int XW = (CW > sfm_pkg::POS_W) ? CW + 1 : sfm_pkg::POS_W + 1;
	localparam logic [CW-1:0] TEXT_LIMIT = CW'(TEXT_MAX);
	localparam logic [sfm_pkg::LEN_W-1:0] LEN_TOP = sfm_pkg::LEN_W'(PATTERN_MAX);

	logic [sfm_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [sfm_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [sfm_pkg::LEN_W-1:0] len_q;
	sfm_pkg::pat_chars_t pat;

	logic [CW-1:0] cnt_q;
	logic match_seen_q;
	logic [sfm_pkg::POS_W-1:0] match_start_q;
	logic overflow_q;

	logic acc;
	logic buf_full;
	sfm_pkg::cell_ctl_t ctl;
	logic [DEPTH:0][7:0] chain;
	logic [DEPTH-1:0] cell_hit;
	logic [sfm_pkg::LEN_W-1:0] last_sel;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic overflow_now;
	logic len_ok;
	logic enough;
	logic hit;
	sfm_pkg::out_beat_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q <= '0;
			pat_high_q <= '0;
			len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfm_pkg::CFG_PATTERN_LOW: pat_low_q <= cfg_data;
				sfm_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_data;
				sfm_pkg::CFG_PATTERN_LENGTH: len_q <= cfg_data[sfm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat = {pat_high_q, pat_low_q};
	assign acc = in_valid && !in_stall;
	assign in_stall = buf_full;
	assign ctl.shift = acc && !in_data.last_char;
	assign ctl.clear = acc && in_data.last_char;

	assign chain[0] = in_data.text_char;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		sfm_cell #(
			.IDX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.char_in(chain[k]),
			.pat(pat),
			.len(len_q),
			.char_out(chain[k+1]),
			.hit(cell_hit[k])
		);
	end

	assign last_sel = len_q - sfm_pkg::LEN_W'(1);
	assign cnt_x = XW'(cnt_q) + XW'(1);
	assign pos_x = cnt_x - XW'(len_q);
	assign overflow_now = (cnt_q >= TEXT_LIMIT);
	assign len_ok = (len_q >= sfm_pkg::LEN_W'(2)) && (len_q <= LEN_TOP);
	assign enough = (cnt_x >= XW'(len_q));
	assign hit = !overflow_now && !match_seen_q && len_ok && enough && (&cell_hit)
		&& (in_data.text_char == pat[last_sel[3:0]]);

	always_comb begin
		res.found = match_seen_q || hit;
		res.too_long = overflow_q || overflow_now;
		if (match_seen_q) begin
			res.match_position = match_start_q;
		end else if (hit) begin
			res.match_position = pos_x[sfm_pkg::POS_W-1:0];
		end else begin
			res.match_position = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			match_seen_q <= 1'b0;
			match_start_q <= '0;
			overflow_q <= 1'b0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
			match_seen_q <= 1'b0;
			match_start_q <= '0;
			overflow_q <= 1'b0;
		end else if (ctl.shift) begin
			if (!overflow_now) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (overflow_now) begin
				overflow_q <= 1'b1;
			end
			if (hit) begin
				match_seen_q <= 1'b1;
				match_start_q <= pos_x[sfm_pkg::POS_W-1:0];
			end
		end
	end

	sfm_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(ctl.clear),
		.push_data(res),
		.full(buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	`SFM_ASSERT_NEXT(a_clear_on_last, ctl.clear, (cnt_q == '0) && !match_seen_q && !overflow_q,
		"text state not cleared after last beat")
	`SFM_ASSERT_NOW(a_overflow_saturated, overflow_q, cnt_q == TEXT_LIMIT,
		"overflow flag set below text limit")
	`SFM_ASSERT_NEXT(a_match_held, match_seen_q && !ctl.clear, match_seen_q && $stable(match_start_q),
		"latched match changed before end of text")

endmodule

### sim/testbench.sv
// Self-checking testbench for the streaming substring search unit.
// Beats go through queue-fed driver and monitor processes; a local search model predicts results.
// Depends on sfm_pkg and substring_first_match_unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfm_pkg::*;

	localparam int TEXT_LIMIT = 65536;
	localparam int WIN_LEN = PAT_CHARS - 1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 8;
	localparam int LONG_HOLD = 300;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	substring_first_match_unit #(
		.PATTERN_MAX(PAT_CHARS),
		.TEXT_MAX(TEXT_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// search model state and its copy of the pattern registers
	logic [63:0] pat_lo = '0;
	logic [63:0] pat_hi = '0;
	logic [4:0] pat_len = '0;
	logic [7:0] window_chars [WIN_LEN];
	int unsigned seen_chars = 0;
	bit hit_latched = 1'b0;
	int unsigned hit_start = 0;
	bit text_overflow = 1'b0;

	in_beat_t char_queue [$];
	out_beat_t expected_matches [$];
	logic [7:0] text_buf [$];

	bit in_taken = 1'b0;
	bit idling = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int src_gap = 0;
	int sink_gap = 0;

	int cycle_count = 0;
	int fail_count = 0;
	int chars_taken = 0;
	int texts_sent = 0;
	int settings_used = 0;
	int results_checked = 0;
	int found_count = 0;
	int overflow_count = 0;
	out_beat_t want;

	initial begin
		foreach (window_chars[k])
			window_chars[k] = 8'h00;
	end

	function automatic logic [7:0] pat_byte(input int unsigned k);
		return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
	endfunction

	task automatic search_char(input in_beat_t b);
		int unsigned len;
		bit hit;
		out_beat_t r;
		len = 32'(pat_len);
		if (seen_chars >= TEXT_LIMIT) begin
			text_overflow = 1'b1;
		end else if (!hit_latched && len >= 2 && len <= PAT_CHARS && seen_chars + 1 >= len) begin
			hit = (b.text_char == pat_byte(len - 1));
			for (int k = 0; k + 2 <= len; k++) begin
				if (window_chars[k] != pat_byte(len - 2 - k))
					hit = 1'b0;
			end
			if (hit) begin
				hit_latched = 1'b1;
				hit_start = seen_chars + 1 - len;
			end
		end
		for (int k = WIN_LEN - 1; k > 0; k--)
			window_chars[k] = window_chars[k-1];
		window_chars[0] = b.text_char;
		if (seen_chars < TEXT_LIMIT)
			seen_chars++;
		if (b.last_char) begin
			r.found = hit_latched;
			r.match_position = hit_latched ? hit_start[POS_W-1:0] : '0;
			r.too_long = text_overflow;
			expected_matches.push_back(r);
			foreach (window_chars[k])
				window_chars[k] = 8'h00;
			seen_chars = 0;
			hit_latched = 1'b0;
			hit_start = 0;
			text_overflow = 1'b0;
		end
	endtask

	// monitor: input acceptance feeds the model, output beats are checked
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				search_char(in_data);
				chars_taken++;
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (out_data.found)
					found_count++;
				if (out_data.too_long)
					overflow_count++;
				if (expected_matches.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: found=%0b pos=%0d too_long=%0b",
							out_data.found, out_data.match_position, out_data.too_long);
				end else begin
					want = expected_matches.pop_front();
					if (want.found !== out_data.found
							|| want.match_position !== out_data.match_position
							|| want.too_long !== out_data.too_long) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result %0d mismatch: expected found=%0b pos=%0d ",
								"too_long=%0b, got found=%0b pos=%0d too_long=%0b"},
								results_checked, want.found, want.match_position, want.too_long,
								out_data.found, out_data.match_position, out_data.too_long);
					end
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
					expected_matches.size());
				$display("[substring_first_match_unit] ERROR");
				$finish;
			end
		end
	end

	// driver: new beat only once the previous one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (char_queue.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= char_queue.pop_front();
					if (idling && $urandom_range(0, 9) == 0)
						src_gap = $urandom_range(1, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts plus one long hold on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_stall <= 1'b1;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PATTERN_LOW: pat_lo = val;
			CFG_PATTERN_HIGH: pat_hi = val;
			CFG_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_pattern(input logic [127:0] chars, input logic [LEN_W-1:0] len);
		write_reg(CFG_PATTERN_LOW, chars[63:0]);
		write_reg(CFG_PATTERN_HIGH, chars[127:64]);
		write_reg(CFG_PATTERN_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
		settings_used++;
	endtask

	task automatic random_pattern();
		logic [127:0] chars;
		logic [LEN_W-1:0] len;
		bit narrow;
		narrow = 1'($urandom_range(0, 1));
		for (int k = 0; k < PAT_CHARS; k++)
			chars[8*k +: 8] = narrow ? ($urandom_range(0, 1) ? 8'h61 : 8'h62)
				: 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: len = LEN_W'($urandom_range(0, 1));
			1: len = LEN_W'($urandom_range(PAT_CHARS + 1, 31));
			2: len = LEN_W'(PAT_CHARS);
			default: len = LEN_W'($urandom_range(2, PAT_CHARS));
		endcase
		set_pattern(chars, len);
	endtask

	task automatic fill_random(input int n, input bit mixed);
		int top;
		top = (pat_len >= 2 && pat_len <= PAT_CHARS) ? pat_len - 1 : PAT_CHARS - 1;
		text_buf.delete();
		repeat (n)
			text_buf.push_back((mixed && $urandom_range(0, 1)) ? pat_byte($urandom_range(0, top))
				: 8'($urandom_range(0, 255)));
	endtask

	// copies the first count pattern characters into the text, clipped at PAT_CHARS and at its end
	task automatic plant(input int pos, input int count);
		for (int k = 0; k < count && k < PAT_CHARS && pos + k < text_buf.size(); k++)
			text_buf[pos + k] = pat_byte(k);
	endtask

	task automatic send_text();
		in_beat_t b;
		foreach (text_buf[k]) begin
			b.text_char = text_buf[k];
			b.last_char = (k == text_buf.size() - 1);
			char_queue.push_back(b);
		end
		texts_sent++;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (char_queue.size() != 0 || in_valid || expected_matches.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(input int budget);
		int n;
		while (budget > 0) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 24);
			fill_random(n, $urandom_range(0, 4) != 0);
			if ($urandom_range(0, 3) != 0)
				plant($urandom_range(0, n - 1), int'(pat_len));
			if ($urandom_range(0, 2) == 0)
				plant($urandom_range(0, n - 1), pat_len - 1);
			send_text();
			budget -= n;
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset value: zero-length pattern
		text_buf = '{8'h00, 8'h00};
		send_text();
		drain();

		set_pattern({112'd0, 8'h00, 8'hFF}, 5'd2);
		text_buf = '{8'hFF, 8'h00};
		send_text();
		text_buf = '{8'h00, 8'hFF, 8'hFF, 8'h00};
		send_text();
		text_buf = '{8'hFF};
		send_text();
		drain();

		// unused register index leaves the pattern alone
		write_reg(CFG_SPARE, '1);
		text_buf = '{8'hFF, 8'h00};
		send_text();
		drain();

		write_reg(CFG_PATTERN_LENGTH, 64'd1);
		text_buf = '{8'hFF, 8'hFF};
		send_text();
		drain();
		write_reg(CFG_PATTERN_LENGTH, 64'd31);
		text_buf = '{8'hFF, 8'h00};
		send_text();
		drain();

		set_pattern({128{1'b1}}, 5'd16);
		random_phase(130);
		set_pattern(128'd0, 5'd2);
		random_phase(100);
		repeat (5) begin
			idling = ($urandom_range(0, 3) != 0);
			random_pattern();
			random_phase(130);
		end

		// receiver holds off while short texts keep coming, so the input backs up
		idling = 1'b0;
		set_pattern({$urandom, $urandom, $urandom, $urandom}, 5'd3);
		hold_req = 1'b1;
		repeat (40) begin
			fill_random($urandom_range(2, 4), 1'b1);
			if ($urandom_range(0, 1))
				plant(0, int'(pat_len));
			send_text();
		end
		drain();

		// texts at and beyond the length limit
		set_pattern({$urandom, $urandom, $urandom, $urandom}, 5'd16);
		fill_random(TEXT_LIMIT, 1'b0);
		plant(TEXT_LIMIT - PAT_CHARS, PAT_CHARS);
		send_text();
		fill_random(TEXT_LIMIT + 20, 1'b0);
		plant(TEXT_LIMIT + 2, PAT_CHARS);
		send_text();
		fill_random(TEXT_LIMIT + 4, 1'b0);
		plant(3, PAT_CHARS);
		send_text();
		drain();

		random_pattern();
		random_phase(150);
		drain();

		$display("%0d characters in %0d texts over %0d pattern settings",
			chars_taken, texts_sent, settings_used);
		$display("%0d results checked: %0d with a match, %0d over the length limit",
			results_checked, found_count, overflow_count);
		if (expected_matches.size() != 0)
			$display("%0d expected results never arrived", expected_matches.size());
		if (fail_count == 0 && expected_matches.size() == 0) begin
			$display("[substring_first_match_unit] OK");
		end else begin
			$display("[substring_first_match_unit] ERROR");
		end
		$finish;
	end

endmodule
